>>> src/lve_pkg.sv
`timescale 1ns / 1ps

package lve_pkg;

  localparam int MAX_NORM_SQ = 255;
  localparam int IN_W        = 8;
  localparam int NORM_W      = 9;
  localparam int COORD_W     = 5;
  localparam int STEP_W      = 4;
  localparam int RES_LIMIT   = 64;
  localparam int CNT_W       = 7;
  localparam int RETRY_LIMIT = 8;
  localparam int TRY_W       = 3;
  localparam int PERM_W      = 3;
  localparam int SBIT_W      = 3;

  typedef logic [STEP_W-1:0]  step_t;
  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [PERM_W-1:0]  perm_t;

  // permutation codes of a sorted hit (a,b,c)
  localparam perm_t PERM_ABC  = 3'd0;
  localparam perm_t PERM_ACB  = 3'd1;
  localparam perm_t PERM_BAC  = 3'd2;
  localparam perm_t PERM_BCA  = 3'd3;
  localparam perm_t PERM_CAB  = 3'd4;
  localparam perm_t PERM_CBA  = 3'd5;
  localparam perm_t PERM_NONE = 3'd7;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_INIT_A,
    OP_INIT_B,
    OP_SQ_INIT,
    OP_SQ_STEP,
    OP_HIT,
    OP_GEN,
    OP_INC_B,
    OP_INC_A,
    OP_RETRY,
    OP_FLUSH
  } op_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_IN,
    C_A_DONE,
    C_B_DONE,
    C_SQ_MORE,
    C_NOT_EXACT,
    C_FULL,
    C_PERM_MORE,
    C_HAVE,
    C_TRIES_LEFT
  } cond_t;

  localparam step_t STEP_IDLE    = 4'd0;
  localparam step_t STEP_START   = 4'd1;
  localparam step_t STEP_A_CHECK = 4'd2;
  localparam step_t STEP_B_INIT  = 4'd3;
  localparam step_t STEP_B_CHECK = 4'd4;
  localparam step_t STEP_SQ_INIT = 4'd5;
  localparam step_t STEP_SQ_STEP = 4'd6;
  localparam step_t STEP_HIT     = 4'd7;
  localparam step_t STEP_GEN     = 4'd8;
  localparam step_t STEP_FULL    = 4'd9;
  localparam step_t STEP_MORE    = 4'd10;
  localparam step_t STEP_NEXT_B  = 4'd11;
  localparam step_t STEP_NEXT_A  = 4'd12;
  localparam step_t STEP_END_N   = 4'd13;
  localparam step_t STEP_RETRY   = 4'd14;
  localparam step_t STEP_FINISH  = 4'd15;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } uword_t;

  typedef struct packed {
    logic a_done;
    logic b_done;
    logic sq_more;
    logic not_exact;
    logic full;
    logic perm_more;
    logic have_pend;
    logic tries_left;
    logic stall;
  } flags_t;

  typedef struct packed {
    logic              valid;
    logic [NORM_W-1:0] norm;
    coord_t            x;
    coord_t            y;
    coord_t            z;
    logic              last;
  } push_t;

  // microprogram
  function automatic uword_t ucode_rom(step_t pc);
    uword_t w;
    unique case (pc)
      STEP_IDLE:    w = '{OP_LOAD,    C_NO_IN,      STEP_IDLE};
      STEP_START:   w = '{OP_INIT_A,  C_NEVER,      STEP_IDLE};
      STEP_A_CHECK: w = '{OP_NOP,     C_A_DONE,     STEP_END_N};
      STEP_B_INIT:  w = '{OP_INIT_B,  C_NEVER,      STEP_IDLE};
      STEP_B_CHECK: w = '{OP_NOP,     C_B_DONE,     STEP_NEXT_A};
      STEP_SQ_INIT: w = '{OP_SQ_INIT, C_NEVER,      STEP_IDLE};
      STEP_SQ_STEP: w = '{OP_SQ_STEP, C_SQ_MORE,    STEP_SQ_STEP};
      STEP_HIT:     w = '{OP_HIT,     C_NOT_EXACT,  STEP_NEXT_B};
      STEP_GEN:     w = '{OP_GEN,     C_NEVER,      STEP_IDLE};
      STEP_FULL:    w = '{OP_NOP,     C_FULL,       STEP_FINISH};
      STEP_MORE:    w = '{OP_NOP,     C_PERM_MORE,  STEP_GEN};
      STEP_NEXT_B:  w = '{OP_INC_B,   C_ALWAYS,     STEP_B_CHECK};
      STEP_NEXT_A:  w = '{OP_INC_A,   C_ALWAYS,     STEP_A_CHECK};
      STEP_END_N:   w = '{OP_NOP,     C_HAVE,       STEP_FINISH};
      STEP_RETRY:   w = '{OP_RETRY,   C_TRIES_LEFT, STEP_START};
      STEP_FINISH:  w = '{OP_FLUSH,   C_ALWAYS,     STEP_IDLE};
      default:      w = '{OP_NOP,     C_ALWAYS,     STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

>>> src/lve_useq.sv
`timescale 1ns / 1ps

module lve_useq (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  lve_pkg::flags_t flags,
  output lve_pkg::uword_t uw
);

  lve_pkg::step_t pc;
  lve_pkg::step_t pc_next;
  logic           take;

  assign uw = lve_pkg::ucode_rom(pc);

  always_comb begin
    unique case (uw.cond)
      lve_pkg::C_NEVER:      take = 1'b0;
      lve_pkg::C_ALWAYS:     take = 1'b1;
      lve_pkg::C_NO_IN:      take = !in_valid;
      lve_pkg::C_A_DONE:     take = flags.a_done;
      lve_pkg::C_B_DONE:     take = flags.b_done;
      lve_pkg::C_SQ_MORE:    take = flags.sq_more;
      lve_pkg::C_NOT_EXACT:  take = flags.not_exact;
      lve_pkg::C_FULL:       take = flags.full;
      lve_pkg::C_PERM_MORE:  take = flags.perm_more;
      lve_pkg::C_HAVE:       take = flags.have_pend;
      lve_pkg::C_TRIES_LEFT: take = flags.tries_left;
      default:               take = 1'b0;
    endcase

    priority if (flags.stall) begin
      pc_next = pc;
    end else if (take) begin
      pc_next = uw.target;
    end else begin
      pc_next = pc + lve_pkg::step_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= lve_pkg::STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

>>> src/lve_dpath.sv
`timescale 1ns / 1ps

module lve_dpath (
  input  logic                       clk,
  input  logic                       rst,
  input  lve_pkg::uword_t            uw,
  input  logic                       in_valid,
  input  logic [lve_pkg::IN_W-1:0]   target_norm_sq,
  input  logic                       out_free,
  output lve_pkg::flags_t            flags,
  output lve_pkg::push_t             push
);

  localparam int NW = lve_pkg::NORM_W;
  localparam int CW = lve_pkg::COORD_W;

  logic [NW-1:0]             n;
  logic [NW-1:0]             rest;
  logic [NW-1:0]             rem;
  lve_pkg::coord_t           a;
  lve_pkg::coord_t           b;
  lve_pkg::coord_t           r;
  logic [lve_pkg::SBIT_W-1:0] sbit;
  logic [lve_pkg::CNT_W-1:0] cnt;
  logic [lve_pkg::TRY_W-1:0] tries;
  lve_pkg::perm_t            p;
  lve_pkg::perm_t            p_next;
  logic                      pend_valid;
  lve_pkg::coord_t           pend_x;
  lve_pkg::coord_t           pend_y;
  lve_pkg::coord_t           pend_z;

  logic [2*CW-1:0]           asq;
  logic [2*CW-1:0]           bsq;
  logic [2*CW-1:0]           tsq;
  logic [2*CW-1:0]           rsq;
  logic [2*CW+1:0]           a_lim;
  logic [2*CW:0]             b_lim;
  lve_pkg::coord_t           trial;
  lve_pkg::coord_t           vx;
  lve_pkg::coord_t           vy;
  lve_pkg::coord_t           vz;
  logic [NW-1:0]             n_sat;
  logic                      all_eq;
  logic                      two_eq;
  logic                      push_req;
  logic                      stall;

  always_comb begin
    asq   = {{CW{1'b0}}, a} * {{CW{1'b0}}, a};
    bsq   = {{CW{1'b0}}, b} * {{CW{1'b0}}, b};
    trial = r | (CW'(1) << sbit);
    tsq   = {{CW{1'b0}}, trial} * {{CW{1'b0}}, trial};
    rsq   = {{CW{1'b0}}, r} * {{CW{1'b0}}, r};
    a_lim = {2'b00, asq} + {1'b0, asq, 1'b0};
    b_lim = {bsq, 1'b0};

    // requests above the limit saturate
    if ({2'b00, target_norm_sq} > 10'(lve_pkg::MAX_NORM_SQ)) begin
      n_sat = NW'(lve_pkg::MAX_NORM_SQ);
    end else begin
      n_sat = {1'b0, target_norm_sq};
    end

    all_eq = (a == b) && (b == r);
    two_eq = (a == b) || (b == r);

    unique case (p)
      lve_pkg::PERM_ABC: begin vx = a; vy = b; vz = r; end
      lve_pkg::PERM_ACB: begin vx = a; vy = r; vz = b; end
      lve_pkg::PERM_BAC: begin vx = b; vy = a; vz = r; end
      lve_pkg::PERM_BCA: begin vx = b; vy = r; vz = a; end
      lve_pkg::PERM_CAB: begin vx = r; vy = a; vz = b; end
      lve_pkg::PERM_CBA: begin vx = r; vy = b; vz = a; end
      default:           begin vx = a; vy = b; vz = r; end
    endcase

    // two equal: only the two rotations follow the sorted triple
    priority if (all_eq) begin
      p_next = lve_pkg::PERM_NONE;
    end else if (two_eq) begin
      priority if (p == lve_pkg::PERM_ABC) begin
        p_next = lve_pkg::PERM_BCA;
      end else if (p == lve_pkg::PERM_BCA) begin
        p_next = lve_pkg::PERM_CAB;
      end else begin
        p_next = lve_pkg::PERM_NONE;
      end
    end else if (p == lve_pkg::PERM_CBA) begin
      p_next = lve_pkg::PERM_NONE;
    end else begin
      p_next = p + lve_pkg::perm_t'(1);
    end

    push_req = ((uw.op == lve_pkg::OP_GEN) || (uw.op == lve_pkg::OP_FLUSH)) && pend_valid;
    stall    = push_req && !out_free;

    push.valid = push_req && out_free;
    push.norm  = n;
    push.x     = pend_x;
    push.y     = pend_y;
    push.z     = pend_z;
    push.last  = (uw.op == lve_pkg::OP_FLUSH);

    flags.a_done     = a_lim > {3'b000, n};
    flags.b_done     = b_lim > {2'b00, rest};
    flags.sq_more    = sbit != '0;
    flags.not_exact  = rsq != {1'b0, rem};
    flags.full       = cnt == lve_pkg::CNT_W'(lve_pkg::RES_LIMIT);
    flags.perm_more  = p != lve_pkg::PERM_NONE;
    flags.have_pend  = pend_valid;
    flags.tries_left = tries != lve_pkg::TRY_W'(lve_pkg::RETRY_LIMIT - 1);
    flags.stall      = stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (!stall) begin
      unique case (uw.op)
        lve_pkg::OP_LOAD: begin
          if (in_valid) begin
            n          <= n_sat;
            cnt        <= '0;
            tries      <= '0;
            pend_valid <= 1'b0;
          end
        end
        lve_pkg::OP_INIT_A: begin
          a <= '0;
        end
        lve_pkg::OP_INIT_B: begin
          b    <= a;
          rest <= NW'({1'b0, n} - asq);
        end
        lve_pkg::OP_SQ_INIT: begin
          rem  <= NW'({1'b0, rest} - bsq);
          r    <= '0;
          sbit <= lve_pkg::SBIT_W'(CW - 1);
        end
        lve_pkg::OP_SQ_STEP: begin
          // one root bit per step, msb first
          if (tsq <= {1'b0, rem}) begin
            r <= trial;
          end
          sbit <= sbit - lve_pkg::SBIT_W'(1);
        end
        lve_pkg::OP_HIT: begin
          p <= lve_pkg::PERM_ABC;
        end
        lve_pkg::OP_GEN: begin
          // hold one vector back so the final one can be flagged
          pend_x     <= vx;
          pend_y     <= vy;
          pend_z     <= vz;
          pend_valid <= 1'b1;
          cnt        <= cnt + lve_pkg::CNT_W'(1);
          p          <= p_next;
        end
        lve_pkg::OP_INC_B: begin
          b <= b + CW'(1);
        end
        lve_pkg::OP_INC_A: begin
          a <= a + CW'(1);
        end
        lve_pkg::OP_RETRY: begin
          n     <= n + NW'(1);
          tries <= tries + lve_pkg::TRY_W'(1);
        end
        lve_pkg::OP_FLUSH: begin
          pend_valid <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

>>> src/lattice_vector_enumerator.sv
`timescale 1ns / 1ps

// Takes a squared norm n (saturated to MAX_NORM_SQ) and returns, one beat per
// vector, up to RES_LIMIT non-negative triples with x*x + y*y + z*z = n, sorted
// triples found in order of a then b, each followed by its distinct permutations;
// if n has no representation it is raised by one and searched again, up to
// RETRY_LIMIT norms in all, and the last beat of a request has last_vector set.
// One request is worked at a time by a 16-step microprogram, with a bit-serial
// square root per (a,b) candidate; the search stalls while the output side
// holds back a beat. A new request is taken once the last beat of the previous
// one has entered the output register.
module lattice_vector_enumerator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lve_pkg::IN_W-1:0]      target_norm_sq,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lve_pkg::NORM_W-1:0]    used_norm_sq,
  output logic [lve_pkg::COORD_W-1:0]   coord_x,
  output logic [lve_pkg::COORD_W-1:0]   coord_y,
  output logic [lve_pkg::COORD_W-1:0]   coord_z,
  output logic                          last_vector
);

  lve_pkg::uword_t uw;
  lve_pkg::flags_t dp_flags;
  lve_pkg::push_t  dp_push;
  logic            out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (uw.op == lve_pkg::OP_LOAD);

  lve_useq u_useq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .flags    (dp_flags),
    .uw       (uw)
  );

  lve_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .uw             (uw),
    .in_valid       (in_valid),
    .target_norm_sq (target_norm_sq),
    .out_free       (out_free),
    .flags          (dp_flags),
    .push           (dp_push)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (dp_push.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_push.valid) begin
      used_norm_sq <= dp_push.norm;
      coord_x      <= dp_push.x;
      coord_y      <= dp_push.y;
      coord_z      <= dp_push.z;
      last_vector  <= dp_push.last;
    end
  end

  a_push_into_free: assert property (@(posedge clk) disable iff (rst)
    dp_push.valid |-> out_free)
    else $error("beat pushed while output register is occupied");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !dp_flags.have_pend)
    else $error("sequencer idle with a vector still held back");

  a_accept_clears: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (!dp_flags.have_pend && !in_ready))
    else $error("request accepted but search did not start clean");

  a_stall_only_push: assert property (@(posedge clk) disable iff (rst)
    dp_flags.stall |-> (out_valid && !out_ready && !in_ready))
    else $error("stall without a blocked output beat");

endmodule
